// ===== hw/rtl/dq_pkg.sv =====
// Package for the double-ended queue.
// Holds the request and response beat types, function and status codes, and defaults.
// Used by double_ended_queue under hw/rtl and by its testbench.
package dq_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int WORD_W = 32;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		FUNC_PUSH_FRONT = 2'd0,
		FUNC_PUSH_BACK = 2'd1,
		FUNC_POP_FRONT = 2'd2,
		FUNC_POP_BACK = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_FULL = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		func_t func;
		logic signed [WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		status_t status;
		logic signed [WORD_W-1:0] removed_value;
		logic [COUNT_W-1:0] entry_count;
	} rsp_t;

endpackage

// ===== hw/rtl/dq_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// The read data register only updates when a read is enabled.
// No package dependencies.
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/double_ended_queue.sv =====
// Bounded double-ended queue of signed 32-bit words held as a ring buffer in one
// synchronous RAM of DEPTH words. Each request beat pushes at the front or back or pops
// from the front or back, and yields exactly one response beat with a status (done, full,
// empty), the popped word (zero otherwise) and the entry count after the request,
// truncated to five bits. A request is accepted every cycle while the response side
// keeps up; the response passes through stage 1, which holds the registered RAM read,
// and then the response register. The front index and the count live in registers and are
// updated at acceptance, so a pop right after a push of the same slot reads the new word.
// Depends on dq_pkg and dq_ram.
module double_ended_queue #(
	parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input dq_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output dq_pkg::rsp_t rsp
);

	import dq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = AW + 1;

	logic [AW-1:0] front_q;
	logic [CW-1:0] occ_q;

	logic req_acc;
	logic is_pop;
	logic is_full;
	logic is_empty;
	status_t status;
	logic [AW-1:0] front_dec;
	logic [AW-1:0] front_inc;
	logic [SW-1:0] back_sum;
	logic [SW-1:0] back_last_sum;
	logic [AW-1:0] back_slot;
	logic [AW-1:0] back_last;
	logic [AW-1:0] front_nxt;
	logic [CW-1:0] occ_nxt;
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic ram_re;
	logic [AW-1:0] ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	logic valid_s1;
	logic pop_s1;
	status_t status_s1;
	logic [COUNT_W-1:0] count_s1;
	logic move_s1;

	logic rsp_valid_q;
	rsp_t rsp_q;

	// The RAM read data holds while no new read is issued, so a stalled stage 1 keeps it.
	assign move_s1 = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !move_s1;
	assign req_acc = req_valid && !req_stall;

	assign is_pop = (req.func == FUNC_POP_FRONT) || (req.func == FUNC_POP_BACK);
	assign is_full = (occ_q == CW'(DEPTH));
	assign is_empty = (occ_q == '0);

	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
	assign back_sum = {1'b0, front_q} + SW'(occ_q);
	assign back_last_sum = back_sum - SW'(1);
	assign back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
	assign back_last = (back_last_sum >= SW'(DEPTH)) ?
		AW'(back_last_sum - SW'(DEPTH)) : AW'(back_last_sum);

	always_comb begin
		status = ST_DONE;
		front_nxt = front_q;
		occ_nxt = occ_q;
		ram_we = 1'b0;
		ram_waddr = back_slot;
		ram_re = 1'b0;
		ram_raddr = front_q;
		case (req.func)
			FUNC_PUSH_FRONT: begin
				if (is_full) begin
					status = ST_FULL;
				end else begin
					front_nxt = front_dec;
					occ_nxt = occ_q + CW'(1);
					ram_we = req_acc;
					ram_waddr = front_dec;
				end
			end
			FUNC_PUSH_BACK: begin
				if (is_full) begin
					status = ST_FULL;
				end else begin
					occ_nxt = occ_q + CW'(1);
					ram_we = req_acc;
					ram_waddr = back_slot;
				end
			end
			FUNC_POP_FRONT: begin
				if (is_empty) begin
					status = ST_EMPTY;
				end else begin
					front_nxt = front_inc;
					occ_nxt = occ_q - CW'(1);
					ram_re = req_acc;
					ram_raddr = front_q;
				end
			end
			FUNC_POP_BACK: begin
				if (is_empty) begin
					status = ST_EMPTY;
				end else begin
					occ_nxt = occ_q - CW'(1);
					ram_re = req_acc;
					ram_raddr = back_last;
				end
			end
			default: begin
				status = ST_DONE;
			end
		endcase
	end

	dq_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(req.value),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			occ_q <= '0;
			valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_acc) begin
				front_q <= front_nxt;
				occ_q <= occ_nxt;
			end
			if (req_acc) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (move_s1) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			pop_s1 <= is_pop;
			status_s1 <= status;
			count_s1 <= COUNT_W'(occ_nxt);
		end
		if (move_s1) begin
			rsp_q.status <= status_s1;
			rsp_q.removed_value <= (pop_s1 && (status_s1 == ST_DONE)) ? ram_rdata : '0;
			rsp_q.entry_count <= count_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

// ===== test/double_ended_queue_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue: random push and pop beats against a ring-buffer
// predictor, with bursty requests and patterned response stalls. Depends on dq_pkg.
module double_ended_queue_tb;
	import dq_pkg::*;

	localparam int DEPTH = DEPTH_DEFAULT;
	localparam int RANDOM_BEATS = 1450;

	typedef struct {
		req_t beat;
		bit drain_first;
	} plan_t;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	plan_t plan_q[$];
	rsp_t rsp_due_q[$];

	// Shadow copy of the ring buffer.
	logic [WORD_W-1:0] shadow_mem [DEPTH];
	int unsigned shadow_front = 0;
	int unsigned shadow_count = 0;

	bit req_fired = 1'b0;
	int idle_left = 0;
	int burst_left = 8;
	int unsigned stall_cyc = 0;
	int err_cnt = 0;
	int n_checked = 0;
	int n_popped = 0;
	int n_full = 0;
	int n_empty = 0;

	double_ended_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic rsp_t deque_apply(req_t beat);
		rsp_t r;
		int unsigned slot;
		r.status = ST_DONE;
		r.removed_value = '0;
		case (beat.func)
			FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
				if (shadow_count >= DEPTH) begin
					r.status = ST_FULL;
				end else if (beat.func == FUNC_PUSH_FRONT) begin
					shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
					shadow_mem[shadow_front] = beat.value;
					shadow_count++;
				end else begin
					slot = (shadow_front + shadow_count) % DEPTH;
					shadow_mem[slot] = beat.value;
					shadow_count++;
				end
			end
			default: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else if (beat.func == FUNC_POP_FRONT) begin
					r.removed_value = shadow_mem[shadow_front];
					shadow_front = (shadow_front + 1) % DEPTH;
					shadow_count--;
				end else begin
					slot = (shadow_front + shadow_count - 1) % DEPTH;
					r.removed_value = shadow_mem[slot];
					shadow_count--;
				end
			end
		endcase
		r.entry_count = shadow_count[COUNT_W-1:0];
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 15);
			3: return 32'hffff_ffff - $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	function automatic void plan_request(func_t f, logic [WORD_W-1:0] w, bit drain);
		plan_t p;
		p.beat.func = f;
		p.beat.value = w;
		p.drain_first = drain;
		plan_q.push_back(p);
	endfunction

	// Request driver; inputs change on the falling edge.
	always @(negedge clk) begin
		plan_t cur;
		if (arst_n) begin
			if (!req_valid || req_fired) begin
				if (idle_left > 0) begin
					idle_left--;
					req_valid <= 1'b0;
				end else if (plan_q.size() > 0 &&
						(!plan_q[0].drain_first || rsp_due_q.size() == 0)) begin
					cur = plan_q.pop_front();
					req <= cur.beat;
					req_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
			// The response side cycles through its own stall patterns.
			stall_cyc++;
			case ((stall_cyc / 250) % 4)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 2) == 0);
				2: rsp_stall <= ((stall_cyc % 7) < 3);
				default: rsp_stall <= ($urandom_range(0, 2) != 0);
			endcase
		end
		req_fired = 1'b0;
	end

	// Monitor: predict on each accepted request beat, check each accepted response beat.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				rsp_due_q.push_back(deque_apply(req));
				req_fired = 1'b1;
			end
			if (rsp_valid && !rsp_stall) begin
				if (rsp_due_q.size() == 0) begin
					if (err_cnt < 10)
						$display("Unexpected response beat: status %0d value %0d count %0d",
							rsp.status, rsp.removed_value, rsp.entry_count);
					err_cnt++;
				end else begin
					want = rsp_due_q.pop_front();
					n_checked++;
					if (want.status == ST_FULL) n_full++;
					if (want.status == ST_EMPTY) n_empty++;
					if (want.status == ST_DONE && want.removed_value != 0) n_popped++;
					if (rsp.status !== want.status || rsp.removed_value !== want.removed_value ||
							rsp.entry_count !== want.entry_count) begin
						if (err_cnt < 10)
							$display("Mismatch on response %0d: ", n_checked,
								"status %0d/%0d, ", want.status, rsp.status,
								"value %0d/%0d, ", want.removed_value, rsp.removed_value,
								"count %0d/%0d (expected/actual)",
								want.entry_count, rsp.entry_count);
						err_cnt++;
					end
				end
			end
		end
	end

	initial begin
		int push_pct;
		int seg_left;
		bit drain;
		push_pct = 50;
		seg_left = 0;

		// Empty pops, single-entry push and pop at both ends, then fill past full.
		plan_request(FUNC_POP_FRONT, 32'h1234_5678, 1'b0);
		plan_request(FUNC_POP_BACK, 32'hffff_ffff, 1'b0);
		plan_request(FUNC_PUSH_FRONT, 32'h7fff_ffff, 1'b0);
		plan_request(FUNC_POP_BACK, 32'h0, 1'b0);
		plan_request(FUNC_PUSH_BACK, 32'h8000_0000, 1'b0);
		plan_request(FUNC_POP_FRONT, 32'h0, 1'b0);
		for (int i = 0; i < DEPTH; i++)
			plan_request(func_t'((i % 2) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT), rand_word(),
				1'b0);
		plan_request(FUNC_PUSH_BACK, 32'h5555_5555, 1'b0);
		plan_request(FUNC_PUSH_FRONT, 32'haaaa_aaaa, 1'b0);

		// Random segments lean toward pushing or popping so the queue swings between
		// full and empty with the front index wrapping both ways.
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(10, 60);
				case ($urandom_range(0, 2))
					0: push_pct = 20;
					1: push_pct = 50;
					default: push_pct = 80;
				endcase
			end
			seg_left--;
			drain = (n % 300 == 0);
			if ($urandom_range(0, 99) < push_pct)
				plan_request(func_t'($urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT),
					rand_word(), drain);
			else
				plan_request(func_t'($urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT),
					rand_word(), drain);
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (plan_q.size() != 0 || req_valid) @(posedge clk);
		while (rsp_due_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Checked %0d response beats: %0d pops returned nonzero words, ", n_checked,
			n_popped, "%0d pushes refused as full, %0d pops refused as empty.",
			n_full, n_empty);
		if (err_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
